// File: src/ibmw_pkg.sv
// ----------------------------------------------------------------------------
// ibmw_pkg
// Shared codes, constants and helper functions for the indirect block map
// walker.
// ----------------------------------------------------------------------------
package ibmw_pkg;

    localparam int unsigned DirectCount   = 12;
    localparam int unsigned WordBytes     = 4;
    localparam int unsigned MinBlockBytes = 1024;
    localparam int unsigned SlotCount     = 15;
    localparam int unsigned BasePtrShift  = $clog2(MinBlockBytes / WordBytes);

    localparam logic [3:0] SingleSlot = 4'(DirectCount);
    localparam logic [3:0] DoubleSlot = 4'(DirectCount + 1);
    localparam logic [3:0] TripleSlot = 4'(DirectCount + 2);

    typedef enum logic [1:0] {
        KIND_LOAD      = 2'd0,
        KIND_TRANSLATE = 2'd1,
        KIND_WORD      = 2'd2,
        KIND_UNUSED    = 2'd3
    } in_kind_t;

    typedef enum logic [2:0] {
        RK_FETCH  = 3'd0,
        RK_MAPPED = 3'd1,
        RK_HOLE   = 3'd2,
        RK_RANGE  = 3'd3,
        RK_RDERR  = 3'd4,
        RK_BUSY   = 3'd5
    } result_kind_t;

    typedef enum logic [2:0] {
        TIER_DIRECT = 3'd0,
        TIER_SINGLE = 3'd1,
        TIER_DOUBLE = 3'd2,
        TIER_TRIPLE = 3'd3,
        TIER_RANGE  = 3'd4
    } tier_t;

    // log2 of pointers per indirect block; code three acts as code two
    function automatic logic [3:0] ptr_shift(logic [1:0] code);
        logic [1:0] c;
        c = (code == 2'd3) ? 2'd2 : code;
        return 4'(BasePtrShift) + {2'b00, c};
    endfunction

    // pointer word index of a tier offset at depth k (k levels still below)
    function automatic logic [9:0] ptr_index(logic [31:0] off, logic [1:0] code,
                                             logic [1:0] k);
        logic [3:0]  s;
        logic [4:0]  amt;
        logic [31:0] sh;
        logic [9:0]  msk;
        s = ptr_shift(code);
        unique case (k)
            2'd0:    amt = 5'd0;
            2'd1:    amt = {1'b0, s};
            default: amt = {s, 1'b0};
        endcase
        sh  = off >> amt;
        msk = 10'((11'd1 << s) - 11'd1);
        return sh[9:0] & msk;
    endfunction

endpackage

// File: src/indirect_block_map_walker.sv
// ----------------------------------------------------------------------------
// indirect_block_map_walker
// Translates file block numbers to disk block numbers through an inode's
// direct, single, double and triple indirect pointers.
//
//   Channel  Signals                               Direction
//   in       in_valid/in_ready, kind..read_failed  transfer into the block
//   out      out_valid/out_ready, result_kind..    transfer out of the block
//   cfg      cfg_wr_en, cfg_wr_data                register write, no wait
//
// One item per cycle sustained while results are taken. Stage one does tier
// selection and the pointer memory access, stage two does the walk step with
// the read data and registers the result. Reset clears the walk state and the
// block size code; pointer slots are undefined until loaded. A held result
// stalls stage two, and input ready drops only when stage one is also full.
// ----------------------------------------------------------------------------
module indirect_block_map_walker
    import ibmw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [3:0]  pointer_slot,
    input  logic [31:0] pointer_value,
    input  logic [31:0] logical_block,
    input  logic [31:0] fetched_word,
    input  logic        read_failed,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  result_kind,
    output logic [31:0] block_number,
    output logic [9:0]  word_index
);

    logic [1:0]  log_block_size_reg;

    logic [31:0] ptr_mem [SlotCount];
    logic [31:0] rdata_reg;

    logic        s1_valid_reg;
    in_kind_t    s1_kind_reg;
    tier_t       s1_tier_reg;
    logic [31:0] s1_off_reg;
    logic [31:0] s1_word_reg;
    logic        s1_failed_reg;

    logic        walk_active_reg, walk_active_next;
    logic [1:0]  levels_left_reg, levels_left_next;
    logic [31:0] tier_offset_reg, tier_offset_next;

    logic        out_valid_reg;
    logic [2:0]  result_kind_reg;
    logic [31:0] block_number_reg;
    logic [9:0]  word_index_reg;

    logic        in_fire;
    logic        s1_adv;
    logic        gen;
    logic [2:0]  gen_kind;
    logic [31:0] gen_block;
    logic [9:0]  gen_index;

    // ---------------- stage one: tier select and pointer memory ----------------
    logic [3:0]  sh;
    logic [31:0] bound1, bound2, bound3;
    tier_t       tier;
    logic [31:0] tier_base;
    logic [3:0]  rd_addr;
    logic [1:0]  lv_dec;

    always_comb
    begin
        sh     = ptr_shift(log_block_size_reg);
        bound1 = 32'(DirectCount) + (32'd1 << sh);
        bound2 = bound1 + (32'd1 << {sh, 1'b0});
        bound3 = bound2 + (32'd1 << (5'(sh) + {sh, 1'b0}));
        priority if (logical_block < 32'(DirectCount))
        begin
            tier      = TIER_DIRECT;
            tier_base = 32'd0;
            rd_addr   = logical_block[3:0];
        end
        else if (logical_block < bound1)
        begin
            tier      = TIER_SINGLE;
            tier_base = 32'(DirectCount);
            rd_addr   = SingleSlot;
        end
        else if (logical_block < bound2)
        begin
            tier      = TIER_DOUBLE;
            tier_base = bound1;
            rd_addr   = DoubleSlot;
        end
        else if (logical_block < bound3)
        begin
            tier      = TIER_TRIPLE;
            tier_base = bound2;
            rd_addr   = TripleSlot;
        end
        else
        begin
            tier      = TIER_RANGE;
            tier_base = bound2;
            rd_addr   = TripleSlot;
        end
    end

    assign in_fire  = in_valid && in_ready;
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk)
    begin
        if (in_fire && in_kind_t'(kind) == KIND_LOAD && pointer_slot < 4'(SlotCount))
        begin
            ptr_mem[pointer_slot] <= pointer_value;
        end
        if (in_fire)
        begin
            rdata_reg <= ptr_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_block_size_reg <= 2'd0;
            s1_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                log_block_size_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg   <= in_kind_t'(kind);
            s1_tier_reg   <= tier;
            s1_off_reg    <= logical_block - tier_base;
            s1_word_reg   <= fetched_word;
            s1_failed_reg <= read_failed;
        end
    end

    // ---------------- stage two: walk step ----------------
    always_comb
    begin
        gen              = 1'b0;
        gen_kind         = RK_FETCH;
        gen_block        = 32'd0;
        gen_index        = 10'd0;
        walk_active_next = walk_active_reg;
        levels_left_next = levels_left_reg;
        tier_offset_next = tier_offset_reg;
        lv_dec           = (levels_left_reg != 2'd0) ? levels_left_reg - 2'd1 : 2'd0;

        unique case (s1_kind_reg)
            KIND_TRANSLATE:
            begin
                gen = 1'b1;
                if (walk_active_reg)
                begin
                    gen_kind = RK_BUSY;
                end
                else
                begin
                    unique case (s1_tier_reg)
                        TIER_DIRECT:
                        begin
                            if (rdata_reg == 32'd0)
                            begin
                                gen_kind = RK_HOLE;
                            end
                            else
                            begin
                                gen_kind  = RK_MAPPED;
                                gen_block = rdata_reg;
                            end
                        end
                        TIER_SINGLE, TIER_DOUBLE, TIER_TRIPLE:
                        begin
                            if (rdata_reg == 32'd0)
                            begin
                                gen_kind = RK_HOLE;
                            end
                            else
                            begin
                                walk_active_next = 1'b1;
                                levels_left_next = s1_tier_reg[1:0];
                                tier_offset_next = s1_off_reg;
                                gen_kind         = RK_FETCH;
                                gen_block        = rdata_reg;
                                gen_index        = ptr_index(s1_off_reg, log_block_size_reg,
                                                             s1_tier_reg[1:0] - 2'd1);
                            end
                        end
                        default:
                        begin
                            gen_kind = RK_RANGE;
                        end
                    endcase
                end
            end
            KIND_WORD:
            begin
                if (walk_active_reg)
                begin
                    gen = 1'b1;
                    if (s1_failed_reg || s1_word_reg == 32'd0 || lv_dec == 2'd0)
                    begin
                        walk_active_next = 1'b0;
                        levels_left_next = 2'd0;
                        tier_offset_next = 32'd0;
                    end
                    priority if (s1_failed_reg)
                    begin
                        gen_kind = RK_RDERR;
                    end
                    else if (s1_word_reg == 32'd0)
                    begin
                        gen_kind = RK_HOLE;
                    end
                    else if (lv_dec == 2'd0)
                    begin
                        gen_kind  = RK_MAPPED;
                        gen_block = s1_word_reg;
                    end
                    else
                    begin
                        levels_left_next = lv_dec;
                        gen_kind         = RK_FETCH;
                        gen_block        = s1_word_reg;
                        gen_index        = ptr_index(tier_offset_reg, log_block_size_reg,
                                                     lv_dec - 2'd1);
                    end
                end
            end
            default:
            begin
                gen = 1'b0;
            end
        endcase
    end

    assign s1_adv = s1_valid_reg && (!gen || !out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_active_reg <= 1'b0;
            levels_left_reg <= 2'd0;
            tier_offset_reg <= 32'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                walk_active_reg <= walk_active_next;
                levels_left_reg <= levels_left_next;
                tier_offset_reg <= tier_offset_next;
            end
            if (s1_adv && gen)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && gen)
        begin
            result_kind_reg  <= gen_kind;
            block_number_reg <= gen_block;
            word_index_reg   <= gen_index;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = result_kind_reg;
    assign block_number = block_number_reg;
    assign word_index   = word_index_reg;

    // ---------------- checks ----------------
    a_idle_no_levels: assert property (@(posedge clk) disable iff (!rst_n)
        !walk_active_reg |-> levels_left_reg == 2'd0)
        else $error("levels left while no walk active");

    a_walk_has_levels: assert property (@(posedge clk) disable iff (!rst_n)
        walk_active_reg |-> levels_left_reg != 2'd0)
        else $error("walk active with no levels left");

    a_busy_reply: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_kind_reg == KIND_TRANSLATE && walk_active_reg
        |=> out_valid_reg && result_kind_reg == RK_BUSY)
        else $error("translate during walk not answered busy");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg)
        else $error("stalled stage one item lost");

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb - indirect block map walker testbench
// Loads the inode pointer slots, then drives translate requests through the
// direct, single, double and triple indirect tiers and answers the fetch
// requests with pointer words. A predictor tracks pointers, walk state and the
// block size code and queues the expected results. Results are checked in
// order against that queue. Random idling on both channels, with one phase
// that has none, and block size changes between phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ibmw_pkg::*;

    typedef struct packed {
        in_kind_t    kind;
        logic [3:0]  slot;
        logic [31:0] value;
        logic [31:0] fblock;
        logic [31:0] word;
        logic        failed;
    } map_item_t;

    typedef struct packed {
        result_kind_t kind;
        logic [31:0]  blk;
        logic [9:0]   idx;
    } map_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_data = 2'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  kind = 2'd0;
    logic [3:0]  pointer_slot = 4'd0;
    logic [31:0] pointer_value = 32'd0;
    logic [31:0] logical_block = 32'd0;
    logic [31:0] fetched_word = 32'd0;
    logic        read_failed = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  result_kind;
    logic [31:0] block_number;
    logic [9:0]  word_index;

    map_item_t   pending_items[$];
    map_result_t due_results[$];
    map_item_t   held_item;
    map_result_t want;
    bit          calm = 1'b0;
    int          errors = 0;
    int unsigned phase_code[5] = '{2, 1, 3, 0, 2};

    // predictor state
    logic [31:0] ptr_table[SlotCount];
    logic [1:0]  bs_code = 2'd0;
    bit          walking = 1'b0;
    int unsigned depth_left = 0;
    logic [31:0] walk_off = 32'd0;

    indirect_block_map_walker i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .pointer_slot  (pointer_slot),
        .pointer_value (pointer_value),
        .logical_block (logical_block),
        .fetched_word  (fetched_word),
        .read_failed   (read_failed),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .block_number  (block_number),
        .word_index    (word_index)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned cur_shift();
        return BasePtrShift + ((bs_code == 2'd3) ? 2 : bs_code);
    endfunction

    // first file block of a tier (tier 4 gives the end of the map)
    function automatic longint unsigned tier_start(int unsigned tier, int unsigned s);
        longint unsigned base;
        int unsigned lv;
        base = DirectCount;
        for (lv = 1; lv < tier; lv++)
            base += 64'd1 << (s * lv);
        return base;
    endfunction

    function automatic void expect_result(result_kind_t k, logic [31:0] b, logic [9:0] i);
        due_results.push_back(map_result_t'{k, b, i});
    endfunction

    function automatic void end_walk();
        walking = 1'b0;
        depth_left = 0;
        walk_off = 32'd0;
    endfunction

    function automatic void map_step(map_item_t it);
        int unsigned s;
        int unsigned t;
        longint unsigned n;
        longint unsigned span;
        longint unsigned msk;
        logic [31:0] root;
        bit found;
        s = cur_shift();
        msk = (64'd1 << s) - 1;
        case (it.kind)
            KIND_LOAD:
            begin
                if (it.slot < SlotCount)
                    ptr_table[it.slot] = it.value;
            end
            KIND_TRANSLATE:
            begin
                n = it.fblock;
                found = 1'b0;
                if (walking)
                    expect_result(RK_BUSY, 32'd0, 10'd0);
                else if (n < DirectCount)
                begin
                    root = ptr_table[int'(n)];
                    if (root == 32'd0)
                        expect_result(RK_HOLE, 32'd0, 10'd0);
                    else
                        expect_result(RK_MAPPED, root, 10'd0);
                end
                else
                begin
                    n -= DirectCount;
                    for (t = 1; t <= 3 && !found; t++)
                    begin
                        span = 64'd1 << (s * t);
                        if (n < span)
                        begin
                            found = 1'b1;
                            root = ptr_table[DirectCount + t - 1];
                            if (root == 32'd0)
                                expect_result(RK_HOLE, 32'd0, 10'd0);
                            else
                            begin
                                walking = 1'b1;
                                depth_left = t;
                                walk_off = n[31:0];
                                expect_result(RK_FETCH, root,
                                              10'((n >> (s * (t - 1))) & msk));
                            end
                        end
                        else
                            n -= span;
                    end
                    if (!found)
                        expect_result(RK_RANGE, 32'd0, 10'd0);
                end
            end
            KIND_WORD:
            begin
                if (walking)
                begin
                    if (it.failed)
                    begin
                        end_walk();
                        expect_result(RK_RDERR, 32'd0, 10'd0);
                    end
                    else
                    begin
                        if (depth_left > 0)
                            depth_left--;
                        if (it.word == 32'd0)
                        begin
                            end_walk();
                            expect_result(RK_HOLE, 32'd0, 10'd0);
                        end
                        else if (depth_left == 0)
                        begin
                            end_walk();
                            expect_result(RK_MAPPED, it.word, 10'd0);
                        end
                        else
                            expect_result(RK_FETCH, it.word,
                                10'((longint'(walk_off) >> (s * (depth_left - 1))) & msk));
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // unused fields carry random values
    function automatic map_item_t raw_item(in_kind_t k);
        map_item_t it;
        it.kind = k;
        it.slot = 4'($urandom);
        it.value = $urandom;
        it.fblock = $urandom;
        it.word = $urandom;
        it.failed = 1'($urandom);
        return it;
    endfunction

    function automatic void push_load(logic [3:0] slot, logic [31:0] value);
        map_item_t it;
        it = raw_item(KIND_LOAD);
        it.slot = slot;
        it.value = value;
        pending_items.push_back(it);
    endfunction

    function automatic void push_translate(logic [31:0] fb);
        map_item_t it;
        it = raw_item(KIND_TRANSLATE);
        it.fblock = fb;
        pending_items.push_back(it);
    endfunction

    function automatic void push_word(logic [31:0] w, logic f);
        map_item_t it;
        it = raw_item(KIND_WORD);
        it.word = w;
        it.failed = f;
        pending_items.push_back(it);
    endfunction

    function automatic logic [31:0] rand_ptr();
        return ($urandom_range(7) == 0) ? 32'd0 : $urandom;
    endfunction

    // translate into an indirect tier plus the words it asks for;
    // a broken walk stops short and can leave the walk running
    function automatic void push_walk(int unsigned tier, bit broken);
        int unsigned s;
        int unsigned words;
        int unsigned w;
        longint unsigned span;
        longint unsigned off;
        s = cur_shift();
        span = 64'd1 << (s * tier);
        case ($urandom_range(9))
            0:       off = 0;
            1:       off = span - 1;
            default: off = {$urandom, $urandom} % span;
        endcase
        push_translate(32'(tier_start(tier, s) + off));
        words = broken ? $urandom_range(tier - 1) : tier;
        for (w = 0; w < words; w++)
        begin
            if ($urandom_range(19) == 0)
            begin
                if ($urandom_range(1) == 1)
                    push_translate($urandom);
                else
                    push_load(4'($urandom_range(SlotCount - 1)), rand_ptr());
            end
            case ($urandom_range(23))
                0:       push_word($urandom, 1'b1);
                1:       push_word(32'd0, 1'b0);
                2:       push_word(32'hFFFF_FFFF, 1'b0);
                default: push_word($urandom, 1'b0);
            endcase
        end
    endfunction

    function automatic void push_out_of_range();
        longint unsigned total;
        total = tier_start(4, cur_shift());
        case ($urandom_range(3))
            0:       push_translate(32'hFFFF_FFFF);
            1:       push_translate(32'(total));
            default: push_translate(32'(total + ({$urandom, $urandom} %
                                                 (64'h1_0000_0000 - total))));
        endcase
    endfunction

    function automatic void random_phase(int budget);
        int done;
        int unsigned r;
        int unsigned tier;
        int unsigned k;
        done = 0;
        for (k = 0; k <= $urandom_range(4); k++)
            push_load(4'($urandom_range(SlotCount - 1)), rand_ptr());
        while (done < budget)
        begin
            r = $urandom_range(99);
            if (r < 55)
            begin
                tier = $urandom_range(3, 1);
                push_walk(tier, 1'b0);
                done += tier + 1;
            end
            else if (r < 65)
            begin
                push_translate($urandom_range(DirectCount - 1));
                done++;
            end
            else if (r < 72)
            begin
                push_out_of_range();
                done++;
            end
            else if (r < 78)
            begin
                push_load(4'($urandom_range(SlotCount - 1)), rand_ptr());
                done++;
            end
            else if (r < 84)
            begin
                push_walk($urandom_range(3, 1), 1'b1);
                done++;
            end
            else if (r < 88)
                push_word($urandom, 1'($urandom));
            else if (r < 91)
            begin
                if ($urandom_range(1) == 1)
                    push_load(4'd15, $urandom);
                else
                    pending_items.push_back(raw_item(KIND_UNUSED));
            end
            else
            begin
                push_translate($urandom);
                done++;
            end
        end
    endfunction

    task automatic settle();
        while (pending_items.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_block_size(logic [1:0] code);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= code;
        bs_code = code;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                map_step(held_item);
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 13))
                begin
                    held_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    kind <= held_item.kind;
                    pointer_slot <= held_item.slot;
                    pointer_value <= held_item.value;
                    logical_block <= held_item.fblock;
                    fetched_word <= held_item.word;
                    read_failed <= held_item.failed;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transfer, expected none, got kind=%0d blk=%h idx=%0d",
                             $realtime, result_kind, block_number, word_index);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result_kind !== want.kind || block_number !== want.blk ||
                        word_index !== want.idx)
                    begin
                        errors++;
                        $display("%0t: exp kind=%0d blk=%h idx=%0d, got kind=%0d blk=%h idx=%0d",
                                 $realtime, want.kind, want.blk, want.idx,
                                 result_kind, block_number, word_index);
                    end
                end
            end
            out_ready <= calm || ($urandom_range(99) >= 13);
        end
    end

    initial
    begin
        int unsigned i;
        int unsigned ph;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_block_size(2'd0);

        for (i = 0; i < SlotCount; i++)
            push_load(4'(i), (i == 0) ? 32'hFFFF_FFFF : (i == 11) ? 32'd0 : ($urandom | 32'd1));
        push_translate(32'd0);
        push_translate(32'd11);
        push_translate(32'hFFFF_FFFF);
        push_translate(32'(DirectCount));
        push_translate(32'd3);
        push_load(4'd15, $urandom);
        pending_items.push_back(raw_item(KIND_UNUSED));
        push_load(4'd5, $urandom | 32'd1);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word($urandom, 1'b1);
        push_translate(32'(tier_start(4, cur_shift()) - 1));
        push_word(32'd0, 1'b0);
        push_load(DoubleSlot, 32'd0);
        push_translate(32'(tier_start(2, cur_shift())));
        push_load(DoubleSlot, $urandom | 32'd1);
        push_translate(32'(tier_start(2, cur_shift())));
        push_word($urandom, 1'b1);
        // triple walk left open across the next block size change
        push_translate(32'(tier_start(3, cur_shift()) + 77));
        push_word($urandom | 32'd1, 1'b0);

        for (ph = 0; ph < 5; ph++)
        begin
            settle();
            set_block_size(2'(phase_code[ph]));
            calm = (ph == 2);
            random_phase(315);
        end
        settle();

        if (due_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $realtime, due_results.size());
        end
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
